// ----- rtl/small_language_tokenizer_core_macros.svh -----
// Assertion macros for the small language tokenizer.
// Included by the RTL files that carry concurrent checks.
`ifndef SMALL_LANGUAGE_TOKENIZER_CORE_MACROS_SVH
`define SMALL_LANGUAGE_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLTOK_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sltok: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLTOK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sltok: assertion failed");

`endif

// ----- rtl/sltok_pkg.sv -----
// Shared types, constants and lookup functions of the tokenizer.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package sltok_pkg;

  localparam int unsigned MaxLexeme = 32;
  localparam int unsigned LenW      = $clog2(MaxLexeme + 1);
  localparam int unsigned IdxW      = $clog2(MaxLexeme);
  localparam int unsigned KwCount   = 7;
  localparam int unsigned KwMaxLen  = 6;

  typedef logic [4:0] kind_t;

  localparam kind_t KindEof    = 5'd0;
  localparam kind_t KindErr    = 5'd1;
  localparam kind_t KindAssign = 5'd2;
  localparam kind_t KindEq     = 5'd3;
  localparam kind_t KindAnd    = 5'd16;
  localparam kind_t KindInt    = 5'd17;
  localparam kind_t KindId     = 5'd18;
  localparam kind_t KindStr    = 5'd19;
  localparam kind_t KindKw0    = 5'd20;

  localparam logic [1:0] ActChar = 2'd0;
  localparam logic [1:0] ActEnd  = 2'd1;

  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLcN    = 8'h6E;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChUnder  = 8'h5F;

  typedef enum logic [2:0] {
    ModeStart, ModeComment, ModeEq, ModeAmp, ModeNum, ModeWord, ModeStr, ModeEsc
  } mode_e;

  typedef enum logic [1:0] {
    StIdle, StExec, StFlRd, StFlOut
  } state_e;

  typedef struct packed {
    logic  capture;
    logic  push;
    logic  push_nl;
    logic  clear;
    logic  rd_start;
    logic  rd_next;
    logic  load_tok;
    logic  load_byte;
    kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic  is_char;
    logic  is_eof;
    logic  is_space;
    logic  is_hash;
    logic  is_eq;
    logic  is_amp;
    logic  is_quote;
    logic  is_bslash;
    logic  is_lc_n;
    logic  is_nl;
    logic  is_digit;
    logic  is_word_start;
    logic  punct_hit;
    kind_t punct_kind;
    logic  kw_hit;
    kind_t kw_kind;
    logic  len_zero;
    logic  rd_last;
    logic  out_free;
  } dp_sts_t;

  // Punctuation kind, or KindErr when the byte is not punctuation.
  function automatic kind_t punct_kind(input logic [7:0] ch);
    kind_t k;
    case (ch)
      8'h5B:   k = 5'd4;   // [
      8'h5D:   k = 5'd5;   // ]
      8'h2C:   k = 5'd6;   // ,
      8'h28:   k = 5'd7;   // (
      8'h29:   k = 5'd8;   // )
      8'h7B:   k = 5'd9;   // {
      8'h7D:   k = 5'd10;  // }
      8'h2D:   k = 5'd11;  // -
      8'h3C:   k = 5'd12;  // <
      8'h2B:   k = 5'd13;  // +
      8'h2A:   k = 5'd14;  // *
      8'h2E:   k = 5'd15;  // .
      default: k = KindErr;
    endcase
    return k;
  endfunction

  // Keyword text, first character in the top byte, zero padded.
  function automatic logic [47:0] kw_text(input logic [2:0] k);
    logic [47:0] w;
    case (k)
      3'd0:    w = {"nil", 24'h0};
      3'd1:    w = {"if", 32'h0};
      3'd2:    w = {"while", 8'h0};
      3'd3:    w = {"print", 8'h0};
      3'd4:    w = {"func", 16'h0};
      3'd5:    w = "return";
      3'd6:    w = "struct";
      default: w = 48'h0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] n;
    case (k)
      3'd0:    n = 3'd3;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd5;
      3'd3:    n = 3'd5;
      3'd4:    n = 3'd4;
      3'd5:    n = 3'd6;
      3'd6:    n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Character p of keyword k; only valid for p below KwMaxLen.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [47:0] w;
    w = kw_text(k) << {p, 3'b000};
    return w[47:40];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sltok_if.sv -----
// Valid/ready channel interfaces for tokenizer input items and result tokens.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface sltok_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;

  modport source (output valid, action, char_code, input ready);
  modport sink   (input valid, action, char_code, output ready);
endinterface

interface sltok_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] token_kind;
  logic [7:0] lexeme_byte;
  logic       byte_valid;
  logic       last;
  logic       truncated;

  modport source (output valid, token_kind, lexeme_byte, byte_valid, last, truncated,
                  input ready);
  modport sink   (input valid, token_kind, lexeme_byte, byte_valid, last, truncated,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sltok_ctrl.sv -----
// Tokenizer controller: scan mode, request sequencing and lexeme readout control.
// Depends on sltok_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "small_language_tokenizer_core_macros.svh"

module sltok_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sltok_pkg::dp_sts_t sts_i,
  output sltok_pkg::dp_cmd_t     cmd_o
);

  sltok_pkg::state_e state_q, state_d;
  sltok_pkg::mode_e  mode_q, mode_d;
  sltok_pkg::kind_t  fkind_q;
  logic              redo_q;

  logic              d_emit, d_flush, d_push, d_push_nl, d_clear, d_redo;
  sltok_pkg::kind_t  d_kind;
  logic              emit_now, run_flush, exec_go;

  // Decision for the held item in the current scan mode.
  always_comb begin
    d_emit    = 1'b0;
    d_kind    = sltok_pkg::KindErr;
    d_flush   = 1'b0;
    d_push    = 1'b0;
    d_push_nl = 1'b0;
    d_clear   = 1'b0;
    d_redo    = 1'b0;
    mode_d    = mode_q;
    case (mode_q)
      sltok_pkg::ModeStart: begin
        if (!sts_i.is_char) begin
          d_emit = 1'b1;
          d_kind = sts_i.is_eof ? sltok_pkg::KindEof : sltok_pkg::KindErr;
        end else if (sts_i.is_space) begin
          mode_d = sltok_pkg::ModeStart;
        end else if (sts_i.is_hash) begin
          mode_d = sltok_pkg::ModeComment;
        end else if (sts_i.is_eq) begin
          mode_d = sltok_pkg::ModeEq;
        end else if (sts_i.punct_hit) begin
          d_emit = 1'b1;
          d_kind = sts_i.punct_kind;
        end else if (sts_i.is_digit) begin
          d_clear = 1'b1;
          d_push  = 1'b1;
          mode_d  = sltok_pkg::ModeNum;
        end else if (sts_i.is_word_start) begin
          d_clear = 1'b1;
          d_push  = 1'b1;
          mode_d  = sltok_pkg::ModeWord;
        end else if (sts_i.is_quote) begin
          d_clear = 1'b1;
          mode_d  = sltok_pkg::ModeStr;
        end else if (sts_i.is_amp) begin
          mode_d = sltok_pkg::ModeAmp;
        end else begin
          d_emit = 1'b1;
          d_kind = sltok_pkg::KindErr;
        end
      end
      sltok_pkg::ModeComment: begin
        if (!sts_i.is_char) begin
          mode_d = sltok_pkg::ModeStart;
          d_redo = 1'b1;
        end else if (sts_i.is_nl) begin
          mode_d = sltok_pkg::ModeStart;
        end
      end
      sltok_pkg::ModeEq: begin
        mode_d = sltok_pkg::ModeStart;
        d_emit = 1'b1;
        if (sts_i.is_eq) begin
          d_kind = sltok_pkg::KindEq;
        end else begin
          d_kind = sltok_pkg::KindAssign;
          d_redo = 1'b1;
        end
      end
      sltok_pkg::ModeAmp: begin
        mode_d = sltok_pkg::ModeStart;
        if (sts_i.is_amp) begin
          d_emit = 1'b1;
          d_kind = sltok_pkg::KindAnd;
        end else begin
          d_redo = 1'b1;  // lone '&' is dropped
        end
      end
      sltok_pkg::ModeNum: begin
        if (sts_i.is_digit) begin
          d_push = 1'b1;
        end else begin
          d_flush = 1'b1;
          d_kind  = sltok_pkg::KindInt;
          mode_d  = sltok_pkg::ModeStart;
          d_redo  = 1'b1;
        end
      end
      sltok_pkg::ModeWord: begin
        if (sts_i.is_digit || sts_i.is_word_start) begin
          d_push = 1'b1;
        end else if (sts_i.kw_hit) begin
          d_emit  = 1'b1;
          d_kind  = sts_i.kw_kind;
          d_clear = 1'b1;
          mode_d  = sltok_pkg::ModeStart;
          d_redo  = 1'b1;
        end else begin
          d_flush = 1'b1;
          d_kind  = sltok_pkg::KindId;
          mode_d  = sltok_pkg::ModeStart;
          d_redo  = 1'b1;
        end
      end
      sltok_pkg::ModeStr: begin
        if (!sts_i.is_char || sts_i.is_quote) begin
          d_flush = 1'b1;
          d_kind  = sltok_pkg::KindStr;
          mode_d  = sltok_pkg::ModeStart;
        end else if (sts_i.is_bslash) begin
          mode_d = sltok_pkg::ModeEsc;
        end else begin
          d_push = 1'b1;
        end
      end
      sltok_pkg::ModeEsc: begin
        mode_d = sltok_pkg::ModeStr;
        if (sts_i.is_lc_n) begin
          d_push    = 1'b1;
          d_push_nl = 1'b1;
        end
      end
      default: mode_d = sltok_pkg::ModeStart;
    endcase
  end

  // An empty string goes out as a single token without bytes.
  assign emit_now  = d_emit || (d_flush && sts_i.len_zero);
  assign run_flush = d_flush && !sts_i.len_zero;
  assign exec_go   = (state_q == sltok_pkg::StExec) && (!emit_now || sts_i.out_free);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sltok_pkg::StIdle: begin
        if (in_valid_i) state_d = sltok_pkg::StExec;
      end
      sltok_pkg::StExec: begin
        if (exec_go) begin
          if (run_flush)   state_d = sltok_pkg::StFlRd;
          else if (d_redo) state_d = sltok_pkg::StExec;
          else             state_d = sltok_pkg::StIdle;
        end
      end
      sltok_pkg::StFlRd: state_d = sltok_pkg::StFlOut;
      sltok_pkg::StFlOut: begin
        if (sts_i.out_free) begin
          if (!sts_i.rd_last) state_d = sltok_pkg::StFlRd;
          else if (redo_q)    state_d = sltok_pkg::StExec;
          else                state_d = sltok_pkg::StIdle;
        end
      end
      default: state_d = sltok_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sltok_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sltok_pkg::StExec: begin
        if (exec_go) begin
          cmd_o.push     = d_push;
          cmd_o.push_nl  = d_push_nl;
          cmd_o.clear    = d_clear;
          cmd_o.load_tok = emit_now;
          cmd_o.rd_start = run_flush;
          cmd_o.kind     = d_kind;
        end
      end
      sltok_pkg::StFlOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          cmd_o.kind      = fkind_q;
          cmd_o.rd_next   = !sts_i.rd_last;
          cmd_o.clear     = sts_i.rd_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sltok_pkg::StIdle;
      mode_q  <= sltok_pkg::ModeStart;
      fkind_q <= sltok_pkg::KindEof;
      redo_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        mode_q <= mode_d;
        if (run_flush) begin
          fkind_q <= d_kind;
          redo_q  <= d_redo;
        end
      end
    end
  end

  `SLTOK_ASSERT_IMPL(a_flush_nonempty, clk_i, rst_ni, state_q == sltok_pkg::StFlOut, !sts_i.len_zero)
  `SLTOK_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, cmd_o.load_tok || cmd_o.load_byte, sts_i.out_free)
  `SLTOK_ASSERT_NEXT(a_redo_in_start, clk_i, rst_ni, exec_go && d_redo, mode_q == sltok_pkg::ModeStart)
  `SLTOK_ASSERT_NEXT(a_esc_to_str, clk_i, rst_ni, exec_go && mode_q == sltok_pkg::ModeEsc, mode_q == sltok_pkg::ModeStr)

endmodule

`default_nettype wire

// ----- rtl/sltok_dp.sv -----
// Tokenizer datapath: held item and its classes, lexeme store with keyword
// tracking, readout pointer and output register. Depends on sltok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sltok_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         in_action_i,
  input  wire logic [7:0]         in_char_code_i,
  input  wire sltok_pkg::dp_cmd_t cmd_i,
  output sltok_pkg::dp_sts_t      sts_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [4:0]              out_token_kind_o,
  output logic [7:0]              out_lexeme_byte_o,
  output logic                    out_byte_valid_o,
  output logic                    out_last_o,
  output logic                    out_truncated_o
);

  localparam int unsigned LenW = sltok_pkg::LenW;
  localparam int unsigned IdxW = sltok_pkg::IdxW;
  localparam int unsigned KwN  = sltok_pkg::KwCount;

  logic [1:0]          act_q;
  logic [7:0]          ch_q;
  logic [LenW-1:0]     len_q, len_d, push_pos;
  logic                ovf_q, ovf_d;
  logic [KwN-1:0]      kw_alive_q, kw_alive_d, kw_base;
  logic [IdxW-1:0]     rd_idx_q;
  logic [7:0]          rd_data_q;
  logic [7:0]          mem_q [sltok_pkg::MaxLexeme];
  logic                mem_we;
  logic [7:0]          push_byte;
  logic                is_char, is_alpha;
  logic                rd_last;
  logic                out_free;

  logic                out_valid_q;
  sltok_pkg::kind_t    out_kind_q;
  logic [7:0]          out_byte_q;
  logic                out_bv_q, out_last_q, out_trunc_q;

  // Held item classes
  assign is_char  = (act_q == sltok_pkg::ActChar);
  assign is_alpha = ((ch_q >= "a") && (ch_q <= "z")) || ((ch_q >= "A") && (ch_q <= "Z"));

  always_comb begin
    sts_o               = '0;
    sts_o.is_char       = is_char;
    sts_o.is_eof        = (act_q == sltok_pkg::ActEnd);
    sts_o.is_space      = is_char && ((ch_q == 8'h20) || ((ch_q >= 8'h09) && (ch_q <= 8'h0D)));
    sts_o.is_hash       = is_char && (ch_q == sltok_pkg::ChHash);
    sts_o.is_eq         = is_char && (ch_q == sltok_pkg::ChEq);
    sts_o.is_amp        = is_char && (ch_q == sltok_pkg::ChAmp);
    sts_o.is_quote      = is_char && (ch_q == sltok_pkg::ChQuote);
    sts_o.is_bslash     = is_char && (ch_q == sltok_pkg::ChBslash);
    sts_o.is_lc_n       = is_char && (ch_q == sltok_pkg::ChLcN);
    sts_o.is_nl         = is_char && (ch_q == sltok_pkg::ChNl);
    sts_o.is_digit      = is_char && (ch_q >= "0") && (ch_q <= "9");
    sts_o.is_word_start = is_char && (is_alpha || (ch_q == sltok_pkg::ChUnder));
    sts_o.punct_kind    = sltok_pkg::punct_kind(ch_q);
    sts_o.punct_hit     = is_char && (sts_o.punct_kind != sltok_pkg::KindErr);
    // Keyword match: prefix still alive, exact length, not cut.
    for (int k = KwN - 1; k >= 0; k--) begin
      if (kw_alive_q[k] && !ovf_q &&
          (len_q == LenW'(sltok_pkg::kw_len(3'(k))))) begin
        sts_o.kw_hit  = 1'b1;
        sts_o.kw_kind = sltok_pkg::KindKw0 + 5'(k);
      end
    end
    sts_o.len_zero = (len_q == '0);
    sts_o.rd_last  = rd_last;
    sts_o.out_free = out_free;
  end

  assign rd_last   = ((LenW'(rd_idx_q) + LenW'(1)) == len_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign push_byte = cmd_i.push_nl ? sltok_pkg::ChNl : ch_q;
  assign push_pos  = cmd_i.clear ? '0 : len_q;
  assign kw_base   = cmd_i.clear ? '1 : kw_alive_q;
  assign mem_we    = cmd_i.push && (push_pos != LenW'(sltok_pkg::MaxLexeme));

  // Keyword candidates narrow one byte at a time as the lexeme grows.
  always_comb begin
    for (int k = 0; k < KwN; k++) begin
      kw_alive_d[k] = kw_base[k] && (push_pos < LenW'(sltok_pkg::KwMaxLen)) &&
                      (sltok_pkg::kw_char(3'(k), push_pos[2:0]) == push_byte);
    end
  end

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (cmd_i.clear) begin
      len_d = '0;
      ovf_d = 1'b0;
    end
    if (cmd_i.push) begin
      if (mem_we) len_d = push_pos + LenW'(1);
      else        ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      ovf_q       <= 1'b0;
      kw_alive_q  <= '1;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      if (cmd_i.push)       kw_alive_q <= kw_alive_d;
      else if (cmd_i.clear) kw_alive_q <= '1;
      if (cmd_i.rd_start)     rd_idx_q <= '0;
      else if (cmd_i.rd_next) rd_idx_q <= rd_idx_q + IdxW'(1);
      if (cmd_i.load_tok || cmd_i.load_byte) out_valid_q <= 1'b1;
      else if (out_ready_i)                  out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= in_action_i;
      ch_q  <= in_char_code_i;
    end
    if (cmd_i.load_tok) begin
      out_kind_q  <= cmd_i.kind;
      out_byte_q  <= 8'h00;
      out_bv_q    <= 1'b0;
      out_last_q  <= 1'b1;
      out_trunc_q <= 1'b0;
    end else if (cmd_i.load_byte) begin
      out_kind_q  <= cmd_i.kind;
      out_byte_q  <= rd_data_q;
      out_bv_q    <= 1'b1;
      out_last_q  <= rd_last;
      out_trunc_q <= ovf_q;
    end
  end

  // Lexeme store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[push_pos[IdxW-1:0]] <= push_byte;
    rd_data_q <= mem_q[rd_idx_q];
  end

  assign out_valid_o       = out_valid_q;
  assign out_token_kind_o  = out_kind_q;
  assign out_lexeme_byte_o = out_byte_q;
  assign out_byte_valid_o  = out_bv_q;
  assign out_last_o        = out_last_q;
  assign out_truncated_o   = out_trunc_q;

endmodule

`default_nettype wire

// ----- rtl/small_language_tokenizer_core.sv -----
// Small language tokenizer, top level: joins controller and datapath to the channels.
// Depends on sltok_pkg, sltok_if, sltok_ctrl and sltok_dp.
//
// Usage:
//   in_i takes one request at a time: action (character, end of input, input error)
//   and char_code. out_o gives one result per lexeme byte of an int, id or string
//   token, or a single result for any other token; last marks the end of a run.
//   in_i.ready is high only while the block is idle. An absorbed character is accepted
//   while idle, then decoded. Each lexeme byte is read from the registered read port of
//   the 32-entry lexeme store, then loaded into the output register. A character that
//   ends an int, id or keyword token, or follows a lone '=' or '&', is decoded again; a
//   closing quote is not. When out_o stalls, the output register holds its result and
//   the sequencer waits; no result is lost or repeated. Reset (rst_ni low) puts the
//   scanner in start mode, empties the lexeme and drops any pending result; no clearing
//   pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module small_language_tokenizer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sltok_in_if.sink   in_i,
  sltok_out_if.source out_o
);

  sltok_pkg::dp_cmd_t cmd;
  sltok_pkg::dp_sts_t sts;

  sltok_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sltok_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_action_i       (in_i.action),
    .in_char_code_i    (in_i.char_code),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_token_kind_o  (out_o.token_kind),
    .out_lexeme_byte_o (out_o.lexeme_byte),
    .out_byte_valid_o  (out_o.byte_valid),
    .out_last_o        (out_o.last),
    .out_truncated_o   (out_o.truncated)
  );

endmodule

`default_nettype wire
